/* rtl/core/vcsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vcsa_pkg;

  localparam int unsigned SumW     = 48;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned RadiusW  = 10;
  localparam int unsigned TqW      = 27;  // scale * (r1 + r2)
  localparam int unsigned T2W      = 54;  // tq squared
  localparam int unsigned D2W      = 22;  // d2 kept only below 2^22
  localparam int unsigned DiffW    = 11;  // per-axis |diff| below the far limit
  localparam int unsigned NumW     = 38;  // t2 >> 16
  localparam int unsigned QueueDepth = 2;

  localparam logic [ScaleW-1:0] ScaleReset = 16'd45875;
  localparam logic [SumW-1:0]   SumMax     = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  // one classified pair handed from front to back
  typedef struct packed {
    logic [TqW-1:0] tq;
    logic [D2W-1:0] d2;
    logic           cand;  // not skipped, not far, d2 below 2^22
    logic           last;
  } vcsa_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TEST,
    ST_DIV,
    ST_QSQ,
    ST_PLO,
    ST_PHI,
    ST_TERM,
    ST_ACC,
    ST_FIN
  } vcsa_state_e;

endpackage
`default_nettype wire

/* rtl/core/vcsa_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module vcsa_front #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [vcsa_pkg::ScaleW-1:0]   cfg_data_i,
  input  wire signed [COORD_WIDTH-1:0] own_x_i,
  input  wire signed [COORD_WIDTH-1:0] own_y_i,
  input  wire signed [COORD_WIDTH-1:0] own_z_i,
  input  wire signed [COORD_WIDTH-1:0] contact_x_i,
  input  wire signed [COORD_WIDTH-1:0] contact_y_i,
  input  wire signed [COORD_WIDTH-1:0] contact_z_i,
  input  wire [vcsa_pkg::RadiusW-1:0]  own_radius_i,
  input  wire [vcsa_pkg::RadiusW-1:0]  contact_radius_i,
  input  wire                          skip_i,
  input  wire                          last_i,
  output vcsa_pkg::vcsa_entry_t        entry_o
);
  import vcsa_pkg::*;

  logic [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_data_i;
    end
  end

  function automatic logic [COORD_WIDTH:0] abs_diff(logic signed [COORD_WIDTH-1:0] a,
                                                   logic signed [COORD_WIDTH-1:0] b);
    logic signed [COORD_WIDTH:0] d;
    d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    abs_diff = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(1) + ~d : d;
    return abs_diff;
  endfunction

  logic [COORD_WIDTH:0] dx, dy, dz;
  logic                 far;
  logic [D2W+1:0]       d2;
  logic [RadiusW:0]     rsum;

  always_comb begin
    dx   = abs_diff(own_x_i, contact_x_i);
    dy   = abs_diff(own_y_i, contact_y_i);
    dz   = abs_diff(own_z_i, contact_z_i);
    far  = (|dx[COORD_WIDTH:DiffW]) | (|dy[COORD_WIDTH:DiffW]) | (|dz[COORD_WIDTH:DiffW]);
    d2   = (D2W+2)'(dx[DiffW-1:0] * dx[DiffW-1:0])
         + (D2W+2)'(dy[DiffW-1:0] * dy[DiffW-1:0])
         + (D2W+2)'(dz[DiffW-1:0] * dz[DiffW-1:0]);
    rsum = {1'b0, own_radius_i} + {1'b0, contact_radius_i};
    entry_o.tq   = TqW'(scale_q * rsum);
    entry_o.d2   = d2[D2W-1:0];
    entry_o.cand = !skip_i && !far && (d2[D2W+1:D2W] == 2'b00);
    entry_o.last = last_i;
  end

endmodule
`default_nettype wire

/* rtl/core/vcsa_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module vcsa_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  vcsa_pkg::vcsa_entry_t push_data_i,
  output logic                  push_ready_o,
  input  wire                   pop_i,
  output vcsa_pkg::vcsa_entry_t pop_data_o,
  output logic                  pop_valid_o
);
  import vcsa_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  vcsa_entry_t         mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  assign push_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && push_ready_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && push_ready_o) wr_q <= wr_q + 1'b1;
      if (pop_i && pop_valid_o)   rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i && push_ready_o) - (PtrW+1)'(pop_i && pop_valid_o);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/vcsa_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module vcsa_divider (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [vcsa_pkg::NumW-1:0]   num_i,
  input  wire [vcsa_pkg::D2W-1:0]    den_i,
  output logic                       done_o,
  output logic [vcsa_pkg::NumW-1:0]  quo_o
);
  import vcsa_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] n_q;
  logic [D2W-1:0]  den_q;
  logic [D2W:0]    rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [D2W:0]    shifted, diff;

  always_comb begin
    shifted = {rem_q[D2W-1:0], n_q[NumW-1]};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[D2W]) begin
        rem_q <= diff;
        n_q   <= {n_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        n_q   <= {n_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule
`default_nettype wire

/* rtl/core/vcsa_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module vcsa_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  vcsa_pkg::vcsa_entry_t        entry_i,
  input  wire                          entry_valid_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [vcsa_pkg::SumW-1:0]    out_sum_o,
  output logic [vcsa_pkg::CountW-1:0]  out_count_o,
  output logic                         out_sat_o
);
  import vcsa_pkg::*;

  vcsa_state_e state_q, state_d;

  logic [TqW-1:0]    tq_q;
  logic [D2W-1:0]    d2_q;
  logic              cand_q, last_q;
  logic [T2W-1:0]    t2_q;
  logic [NumW-1:0]   q_q;
  logic [63:0]       qq_q;
  logic [55:0]       plo_q, phi_q;
  logic [SumW-1:0]   term_q;
  logic              tsat_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] cnt_q;
  logic              ovf_q;
  logic              out_valid_q;
  logic [SumW-1:0]   out_sum_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_sat_q;

  logic              hit, out_free, div_start, div_done;
  logic [NumW-1:0]   div_quo;
  logic [79:0]       prod;
  logic [SumW:0]     sum_ext;

  assign hit      = {d2_q, 32'b0} < t2_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign prod     = {phi_q, 24'b0} + {24'b0, plo_q};
  assign sum_ext  = {1'b0, sum_q} + {1'b0, term_q};

  vcsa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t2_q[T2W-1:16]),
    .den_i   (d2_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (entry_valid_i) state_d = entry_i.cand ? ST_SQUARE : ST_FIN;
      ST_SQUARE: state_d = ST_TEST;
      ST_TEST: begin
        if (!hit)              state_d = ST_FIN;
        else if (d2_q == '0)   state_d = ST_ACC;
        else                   state_d = ST_DIV;
      end
      ST_DIV:    if (div_done) state_d = ST_QSQ;
      ST_QSQ:    state_d = (q_q[NumW-1:32] != '0) ? ST_ACC : ST_PLO;
      ST_PLO:    state_d = ST_PHI;
      ST_PHI:    state_d = ST_TERM;
      ST_TERM:   state_d = ST_ACC;
      ST_ACC:    state_d = ST_FIN;
      ST_FIN:    if (!last_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == ST_IDLE) && entry_valid_i;
    div_start = (state_q == ST_TEST) && hit && (d2_q != '0);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        tq_q   <= entry_i.tq;
        d2_q   <= entry_i.d2;
        cand_q <= entry_i.cand;
        last_q <= entry_i.last;
        tsat_q <= 1'b0;
      end
      ST_SQUARE: t2_q <= T2W'(tq_q * tq_q);
      ST_TEST: begin
        // zero distance: term pinned at full scale
        term_q <= SumMax;
        tsat_q <= 1'b1;
      end
      ST_DIV:  q_q  <= div_quo;
      ST_QSQ: begin
        qq_q   <= q_q[31:0] * q_q[31:0];
        term_q <= SumMax;
        tsat_q <= q_q[NumW-1:32] != '0;
      end
      ST_PLO:  plo_q <= qq_q[39:16] * q_q[31:0];
      ST_PHI:  phi_q <= qq_q[63:40] * q_q[31:0];
      ST_TERM: begin
        tsat_q <= |prod[79:64];
        term_q <= (|prod[79:64]) ? SumMax : prod[63:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        sum_q <= sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
        ovf_q <= ovf_q | tsat_q | sum_ext[SumW];
        if (cnt_q != CountMax) cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_FIN && last_q && out_free) begin
        out_valid_q <= 1'b1;
        sum_q       <= '0;
        cnt_q       <= '0;
        ovf_q       <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && last_q && out_free) begin
      out_sum_q <= sum_q;
      out_cnt_q <= cnt_q;
      out_sat_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_count_o = out_cnt_q;
  assign out_sat_o   = out_sat_q;

  a_div_from_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == ST_TEST && cand_q)
    else $error("divider started outside hit test");
  a_count_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> cnt_q != '0)
    else $error("hit count not advanced");
  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PLO |-> q_q[NumW-1:32] == '0)
    else $error("oversized ratio reached multiplier");
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && last_q && out_free) |=> out_valid_q && sum_q == '0 && !ovf_q)
    else $error("result emit did not clear accumulator");

endmodule
`default_nettype wire

/* rtl/core/vdw_clash_score_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Repulsive van der Waals clash score. Each request is one atom/contact pair;
// for pairs not flagged skip, target T = clash_scale*(r1+r2) and, when the
// distance is below T, (T/D)^6 in Q.16 is added to a saturating 48-bit sum
// and a hit counter goes up. The pair flagged tlast emits {sum, count} with
// the saturation flag on tuser and clears the accumulator. A front stage
// classifies pairs (distances, far check, target) into a two-entry queue;
// the back sequencer does the math: it squares T, tests the hit, runs the
// 38-step restoring divider for (T/D)^2 and forms the product; skipped, far
// or out-of-range pairs skip all of it, misses skip the divider and product,
// and a zero-distance hit adds a full-scale term. A tlast result waits in an
// output register while the next pairs proceed; the back stalls only at the
// next tlast pair while that result is still unread. The user must write
// clash_scale through cfg_* only while idle; the block does not enforce it.
module vdw_clash_score_accumulator #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [15:0]           cfg_data_i,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // own_x, own_y, own_z, contact_x, contact_y, contact_z, own_radius,
  // contact_radius, zero pad
  input  wire [((6*COORD_WIDTH+20+7)/8)*8-1:0] s_axis_tdata,
  input  wire                  s_axis_tlast,   // last_contact
  input  wire                  s_axis_tuser,   // skip_contact
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // clash_sum, clash_count
  output logic                 m_axis_tuser    // saturated
);
  import vcsa_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned RB = 6 * COORD_WIDTH;

  vcsa_entry_t front_entry, queue_entry;
  logic        queue_valid, pop;

  assign cfg_ready_o = 1'b1;

  vcsa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .own_x_i          (s_axis_tdata[CW-1:0]),
    .own_y_i          (s_axis_tdata[2*CW-1:CW]),
    .own_z_i          (s_axis_tdata[3*CW-1:2*CW]),
    .contact_x_i      (s_axis_tdata[4*CW-1:3*CW]),
    .contact_y_i      (s_axis_tdata[5*CW-1:4*CW]),
    .contact_z_i      (s_axis_tdata[6*CW-1:5*CW]),
    .own_radius_i     (s_axis_tdata[RB+9:RB]),
    .contact_radius_i (s_axis_tdata[RB+19:RB+10]),
    .skip_i           (s_axis_tuser),
    .last_i           (s_axis_tlast),
    .entry_o          (front_entry)
  );

  vcsa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid),
    .push_data_i  (front_entry),
    .push_ready_o (s_axis_tready),
    .pop_i        (pop),
    .pop_data_o   (queue_entry),
    .pop_valid_o  (queue_valid)
  );

  vcsa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (queue_entry),
    .entry_valid_i (queue_valid),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_sum_o     (m_axis_tdata[47:0]),
    .out_count_o   (m_axis_tdata[63:48]),
    .out_sat_o     (m_axis_tuser)
  );

endmodule
`default_nettype wire
